FILE: sv/ksl_pkg.sv
// Shared types and constants for the key scanner with long-press repeat.
// Holds field widths, register indexes, reset values and the result struct.
// No dependencies.
package ksl_pkg;

  localparam int KEY_COUNT = 7;
  localparam int TIME_W = 32;
  localparam int REG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [KEY_COUNT-1:0] key_t;
  typedef logic [TIME_W-1:0] tick_t;
  typedef logic [REG_W-1:0] reg_val_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_INTERVAL   = 2'd0,
    REG_LONG_PRESS_TIME = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2
  } cfg_idx_t;

  // Item kinds.
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Long-press report codes.
  typedef enum logic [1:0] {
    LONG_NONE   = 2'd0,
    LONG_HELD   = 2'd1,
    LONG_REPEAT = 2'd2
  } long_code_t;

  localparam reg_val_t READ_INTERVAL_RST   = 16'd20;
  localparam reg_val_t LONG_PRESS_TIME_RST = 16'd1000;
  localparam reg_val_t REPEAT_INTERVAL_RST = 16'd200;

  // One result item.
  typedef struct packed {
    logic       sampled;
    key_t       key_word;
    logic       changed;
    logic       pressed;
    logic       new_press;
    long_code_t long_code;
  } result_t;

endpackage

FILE: sv/ksl_channels.sv
// Valid/ready channel interfaces for the key scanner input and result streams.
// Depends on ksl_pkg for field types.
interface ksl_in_if import ksl_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  action;
  key_t  raw_pins;
  key_t  key_mask;

  modport source (output valid, output action, output raw_pins, output key_mask,
                  input ready);
  modport sink (input valid, input action, input raw_pins, input key_mask,
                output ready);
endinterface

interface ksl_out_if import ksl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       sampled;
  key_t       key_word;
  logic       changed;
  logic       pressed;
  logic       new_press;
  logic [1:0] long_code;

  modport source (output valid, output sampled, output key_word, output changed,
                  output pressed, output new_press, output long_code, input ready);
  modport sink (input valid, input sampled, input key_word, input changed,
                input pressed, input new_press, input long_code, output ready);
endinterface

FILE: sv/ksl_core.sv
// Scanner state, configuration registers and the per-item update logic.
// Depends on ksl_pkg.
module ksl_core
  import ksl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  reg_val_t cfg_wdata,
  input  logic     step,
  input  logic     action,
  input  key_t     raw_pins,
  input  key_t     key_mask,
  output result_t  result
);

  reg_val_t read_interval_r, long_press_time_r, repeat_interval_r;
  tick_t    time_r, time_nxt;
  key_t     key_cur_r, key_cur_nxt;
  key_t     key_prev_r, key_prev_nxt;
  logic     change_r, change_nxt;
  tick_t    change_stamp_r, change_stamp_nxt;
  tick_t    repeat_stamp_r, repeat_stamp_nxt;
  tick_t    sample_stamp_r, sample_stamp_nxt;

  tick_t      time_inc;
  logic       sample_due;
  logic       held;
  logic       repeat_due;
  key_t       key_fresh;
  long_code_t code;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_interval_r   <= READ_INTERVAL_RST;
      long_press_time_r <= LONG_PRESS_TIME_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_READ_INTERVAL:   read_interval_r   <= cfg_wdata;
        REG_LONG_PRESS_TIME: long_press_time_r <= cfg_wdata;
        REG_REPEAT_INTERVAL: repeat_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Elapsed-time tests, all as modulo differences of the tick counter.
  assign time_inc   = time_r + tick_t'(1);
  assign sample_due = (time_inc - sample_stamp_r) > tick_t'(read_interval_r);
  assign held       = (key_prev_r == key_mask) && (key_cur_r == key_mask) &&
                      ((time_r - change_stamp_r) > tick_t'(long_press_time_r));
  assign repeat_due = (time_r - repeat_stamp_r) > tick_t'(repeat_interval_r);
  assign key_fresh  = ~raw_pins;

  // Next state for one item.
  always_comb begin
    time_nxt         = time_r;
    key_cur_nxt      = key_cur_r;
    key_prev_nxt     = key_prev_r;
    change_nxt       = change_r;
    change_stamp_nxt = change_stamp_r;
    repeat_stamp_nxt = repeat_stamp_r;
    sample_stamp_nxt = sample_stamp_r;
    code             = LONG_NONE;
    if (action == ACT_TICK) begin
      time_nxt = time_inc;
      if (sample_due) begin
        sample_stamp_nxt = time_inc;
        key_prev_nxt     = key_cur_r;
        key_cur_nxt      = key_fresh;
        change_nxt       = (key_fresh != key_cur_r);
        if (key_fresh != key_cur_r) begin
          change_stamp_nxt = time_inc;
        end
      end
    end else if (held) begin
      if (repeat_due) begin
        repeat_stamp_nxt = time_r;
        code             = LONG_REPEAT;
      end else begin
        code = LONG_HELD;
      end
    end
  end

  // Result fields come from the state as this item leaves it.
  always_comb begin
    result.sampled   = (action == ACT_TICK) && sample_due;
    result.key_word  = key_cur_nxt;
    result.changed   = change_nxt;
    result.pressed   = |(key_cur_nxt & key_mask);
    result.new_press = change_nxt && (|(key_cur_nxt & key_mask)) &&
                       !(|(key_prev_nxt & key_mask));
    result.long_code = code;
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r         <= '0;
      key_cur_r      <= '0;
      key_prev_r     <= '0;
      change_r       <= 1'b0;
      change_stamp_r <= '0;
      repeat_stamp_r <= '0;
      sample_stamp_r <= '0;
    end else if (step) begin
      time_r         <= time_nxt;
      key_cur_r      <= key_cur_nxt;
      key_prev_r     <= key_prev_nxt;
      change_r       <= change_nxt;
      change_stamp_r <= change_stamp_nxt;
      repeat_stamp_r <= repeat_stamp_nxt;
      sample_stamp_r <= sample_stamp_nxt;
    end
  end

endmodule

FILE: sv/key_scanner_long_press_repeat.sv
// Each result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle; the result register is refilled in the same
// cycle it is emptied, so input stalls only while a result waits unclaimed.
// The item's work is one 32-bit subtract and compare per elapsed-time test.
// Reset (rst_n, synchronous): counter, stamps and keys clear, registers return
// to their defaults, and the result register empties.
module key_scanner_long_press_repeat
  import ksl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  reg_val_t           cfg_wdata,
  ksl_in_if.sink             in_ch,
  ksl_out_if.source          out_ch
);

  logic    accept;
  logic    out_valid_r;
  result_t out_data_r;
  result_t result;

  // A new item may enter whenever the result register is empty or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ksl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .action    (in_ch.action),
    .raw_pins  (in_ch.raw_pins),
    .key_mask  (in_ch.key_mask),
    .result    (result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // Result payload is captured on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sampled   = out_data_r.sampled;
  assign out_ch.key_word  = out_data_r.key_word;
  assign out_ch.changed   = out_data_r.changed;
  assign out_ch.pressed   = out_data_r.pressed;
  assign out_ch.new_press = out_data_r.new_press;
  assign out_ch.long_code = out_data_r.long_code;

endmodule
